@@ rtl/rlfe_pkg.sv @@
// ----------------------------------------------------------------------------
// rlfe_pkg
// Shared types and codes for the RGBW linear fade engine.
// ----------------------------------------------------------------------------
package rlfe_pkg;

  localparam logic CMD_COLOR = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [7:0] FADE_INTERVAL_RESET = 8'd15;
  localparam int         NUM_CH              = 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_EMIT
  } rlfe_state_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic load_out;
  } rlfe_cmd_t;

  typedef struct packed {
    logic emits;
    logic direct;
  } rlfe_status_t;

endpackage

@@ rtl/rlfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlfe_ctrl
// Sequencer: accepts items, runs multiply and divide steps, loads results.
// ----------------------------------------------------------------------------
module rlfe_ctrl #(
  parameter int LEVEL_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rlfe_pkg::rlfe_status_t status,
  output rlfe_pkg::rlfe_cmd_t   cmd
);
  import rlfe_pkg::*;

  localparam int CW = $clog2(LEVEL_BITS);

  rlfe_state_t   state, state_next;
  logic [CW-1:0] div_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV) begin
        div_count <= div_count + CW'(1);
      end else begin
        div_count <= '0;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.emits) state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = status.direct ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_count == CW'(LEVEL_BITS - 1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/rlfe_datapath.sv @@
// ----------------------------------------------------------------------------
// rlfe_datapath
// Fade state, per-channel multipliers and bit-serial dividers, result register.
// ----------------------------------------------------------------------------
module rlfe_datapath #(
  parameter int LEVEL_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rlfe_pkg::rlfe_cmd_t   cmd,
  output rlfe_pkg::rlfe_status_t status,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data,
  input  logic                  in_cmd,
  input  logic [LEVEL_BITS-1:0] in_ch0,
  input  logic [LEVEL_BITS-1:0] in_ch1,
  input  logic [LEVEL_BITS-1:0] in_ch2,
  input  logic [LEVEL_BITS-1:0] in_ch3,
  input  logic                  in_fade,
  output logic [LEVEL_BITS-1:0] drive_0,
  output logic [LEVEL_BITS-1:0] drive_1,
  output logic [LEVEL_BITS-1:0] drive_2,
  output logic [LEVEL_BITS-1:0] drive_3,
  output logic                  fade_done
);
  import rlfe_pkg::*;

  localparam int LB = LEVEL_BITS;
  localparam int PW = 2 * LEVEL_BITS;

  logic [7:0]    fade_interval;
  logic [LB-1:0] start_level  [NUM_CH];
  logic [LB-1:0] target_level [NUM_CH];
  logic [LB-1:0] diff_mag     [NUM_CH];
  logic          diff_neg     [NUM_CH];
  logic [LB-1:0] step_index;
  logic [LB-1:0] step_total;
  logic [7:0]    tick_count;
  logic          fading;
  logic          direct;
  logic [LB-1:0] rem          [NUM_CH];
  logic [LB-1:0] low          [NUM_CH];
  logic [LB-1:0] quo          [NUM_CH];
  logic [LB-1:0] drive        [NUM_CH];

  logic [LB-1:0] in_lv        [NUM_CH];
  logic [LB-1:0] new_mag      [NUM_CH];
  logic [LB-1:0] max01, max23, max_diff;
  logic [PW-1:0] prod         [NUM_CH];
  logic [LB:0]   shifted      [NUM_CH];
  logic          ge           [NUM_CH];
  logic [LB-1:0] rem_next     [NUM_CH];
  logic [LB-1:0] level_next   [NUM_CH];
  logic [7:0]    interval_eff;
  logic [7:0]    tick_inc;
  logic          tick_hit;

  assign in_lv[0] = in_ch0;
  assign in_lv[1] = in_ch1;
  assign in_lv[2] = in_ch2;
  assign in_lv[3] = in_ch3;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      new_mag[ch] = (in_lv[ch] > target_level[ch]) ? in_lv[ch] - target_level[ch]
                                                  : target_level[ch] - in_lv[ch];
      prod[ch]    = PW'(step_index) * PW'(diff_mag[ch]);
      shifted[ch] = {rem[ch], low[ch][LB-1]};
      ge[ch]      = shifted[ch] >= {1'b0, step_total};
      rem_next[ch] = ge[ch] ? LB'(shifted[ch] - {1'b0, step_total}) : LB'(shifted[ch]);
      level_next[ch] = direct      ? target_level[ch] :
                       diff_neg[ch] ? start_level[ch] - quo[ch] :
                                      start_level[ch] + quo[ch];
    end
    max01    = (new_mag[0] > new_mag[1]) ? new_mag[0] : new_mag[1];
    max23    = (new_mag[2] > new_mag[3]) ? new_mag[2] : new_mag[3];
    max_diff = (max01 > max23) ? max01 : max23;
  end

  assign interval_eff  = (fade_interval == 8'd0) ? 8'd1 : fade_interval;
  assign tick_inc      = tick_count + 8'd1;
  assign tick_hit      = tick_inc >= interval_eff;
  assign status.emits  = (in_cmd == CMD_COLOR) || (fading && tick_hit);
  assign status.direct = step_index >= step_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_interval <= FADE_INTERVAL_RESET;
      step_index    <= '0;
      step_total    <= '0;
      tick_count    <= '0;
      fading        <= 1'b0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        start_level[ch]  <= '0;
        target_level[ch] <= '0;
        diff_mag[ch]     <= '0;
        diff_neg[ch]     <= 1'b0;
      end
    end else begin
      if (cfg_we) fade_interval <= cfg_data;
      if (cmd.accept) begin
        if (in_cmd == CMD_COLOR) begin
          for (int ch = 0; ch < NUM_CH; ch++) begin
            start_level[ch]  <= target_level[ch];
            target_level[ch] <= in_lv[ch];
            diff_mag[ch]     <= new_mag[ch];
            diff_neg[ch]     <= in_lv[ch] < target_level[ch];
          end
          tick_count <= '0;
          step_index <= '0;
          step_total <= in_fade ? max_diff : '0;
          fading     <= 1'b1;
        end else if (fading) begin
          if (tick_hit) begin
            tick_count <= '0;
            if (step_index < step_total) step_index <= step_index + LB'(1);
          end else begin
            tick_count <= tick_inc;
          end
        end
      end
      if (cmd.mul && status.direct) fading <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      direct <= status.direct;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        rem[ch] <= prod[ch][PW-1:LB];
        low[ch] <= prod[ch][LB-1:0];
        quo[ch] <= '0;
      end
    end
    if (cmd.div_step) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        rem[ch] <= rem_next[ch];
        low[ch] <= {low[ch][LB-2:0], 1'b0};
        quo[ch] <= {quo[ch][LB-2:0], ge[ch]};
      end
    end
    if (cmd.load_out) begin
      for (int ch = 0; ch < NUM_CH; ch++) drive[ch] <= level_next[ch];
      fade_done <= direct;
    end
  end

  assign drive_0 = drive[0];
  assign drive_1 = drive[1];
  assign drive_2 = drive[2];
  assign drive_3 = drive[3];

endmodule

@@ rtl/rgbw_linear_fade_engine.sv @@
// ----------------------------------------------------------------------------
// rgbw_linear_fade_engine
// Four-channel LED level fader with linear fades between target colors.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd 0 carries four target levels and
// fade_on; cmd 1 is one time tick. Output channel (out_valid/out_ready):
// four drive levels and fade_done. Config channel (cfg_valid/cfg_ready,
// always ready): cfg_data sets fade_interval, the ticks between steps.
// A color item always yields one result; a tick yields one only on every
// fade_interval-th tick of a running fade.
// For a jump, an empty fade or the final step of a fade, the result is
// loaded once the output register is free after the multiply step; for an
// interior step it first passes the bit-serial divider, one quotient bit
// per cycle in each of the four channel lanes. in_ready returns once the
// result is loaded into the output register. A tick that yields no result
// starts no step, and in_ready stays high.
// One item is processed at a time; in_ready drops while a step is computed.
// A finished result waits in the output register while in_ready returns,
// and only the next result load waits for out_ready.
// Reset clears levels, fade state and out_valid; fade_interval returns to 15.
// ----------------------------------------------------------------------------
module rgbw_linear_fade_engine #(
  parameter int LEVEL_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [LEVEL_BITS-1:0] channel_0,
  input  logic [LEVEL_BITS-1:0] channel_1,
  input  logic [LEVEL_BITS-1:0] channel_2,
  input  logic [LEVEL_BITS-1:0] channel_3,
  input  logic                  fade_on,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_BITS-1:0] drive_0,
  output logic [LEVEL_BITS-1:0] drive_1,
  output logic [LEVEL_BITS-1:0] drive_2,
  output logic [LEVEL_BITS-1:0] drive_3,
  output logic                  fade_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_data
);
  import rlfe_pkg::*;

  rlfe_cmd_t    ctl_cmd;
  rlfe_status_t ctl_status;

  assign cfg_ready = 1'b1;

  rlfe_ctrl #(.LEVEL_BITS(LEVEL_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (ctl_status),
    .cmd       (ctl_cmd)
  );

  rlfe_datapath #(.LEVEL_BITS(LEVEL_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl_cmd),
    .status    (ctl_status),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_cmd    (cmd),
    .in_ch0    (channel_0),
    .in_ch1    (channel_1),
    .in_ch2    (channel_2),
    .in_ch3    (channel_3),
    .in_fade   (fade_on),
    .drive_0   (drive_0),
    .drive_1   (drive_1),
    .drive_2   (drive_2),
    .drive_3   (drive_3),
    .fade_done (fade_done)
  );

endmodule

@@ rtl/rlfe_checker.sv @@
// ----------------------------------------------------------------------------
// rlfe_checker
// Port-level checks for the RGBW linear fade engine, bound to the top level.
// ----------------------------------------------------------------------------
module rlfe_checker #(
  parameter int LEVEL_BITS = 10
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  cmd,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [LEVEL_BITS-1:0] drive_0,
  input logic [LEVEL_BITS-1:0] drive_1,
  input logic [LEVEL_BITS-1:0] drive_2,
  input logic [LEVEL_BITS-1:0] drive_3,
  input logic                  fade_done
);
  import rlfe_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_0) && $stable(drive_1)
      && $stable(drive_2) && $stable(drive_3) && $stable(fade_done))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_color_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd == CMD_COLOR |=> !in_ready)
    else $error("color item did not start a step");

endmodule

bind rgbw_linear_fade_engine rlfe_checker #(.LEVEL_BITS(LEVEL_BITS)) u_rlfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .drive_0   (drive_0),
  .drive_1   (drive_1),
  .drive_2   (drive_2),
  .drive_3   (drive_3),
  .fade_done (fade_done)
);

@@ verif/rgbw_linear_fade_engine_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgbw_linear_fade_engine_tb
// Drives color and tick items through the fader under random idling on both
// sides. A local fade model predicts every drive set, and each returned set
// is checked field by field in order. Covers jumps, empty fades, interrupted
// fades, the interval extremes and a long output stall.
// ----------------------------------------------------------------------------
module rgbw_linear_fade_engine_tb;
  import rlfe_pkg::*;

  localparam int LEVEL_BITS  = 10;
  localparam int LEVEL_MAX   = (1 << LEVEL_BITS) - 1;
  localparam int CYCLE_LIMIT = 800000;
  localparam int SETTLE_CYCLES = 20;

  typedef logic [NUM_CH-1:0][LEVEL_BITS-1:0] level_vec_t;

  typedef struct packed {
    level_vec_t drive;
    logic       done;
  } drive_set_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  cmd;
  logic [LEVEL_BITS-1:0] channel_0;
  logic [LEVEL_BITS-1:0] channel_1;
  logic [LEVEL_BITS-1:0] channel_2;
  logic [LEVEL_BITS-1:0] channel_3;
  logic                  fade_on;
  logic                  out_valid;
  logic                  out_ready;
  logic [LEVEL_BITS-1:0] drive_0;
  logic [LEVEL_BITS-1:0] drive_1;
  logic [LEVEL_BITS-1:0] drive_2;
  logic [LEVEL_BITS-1:0] drive_3;
  logic                  fade_done;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [7:0]            cfg_data;

  // fade model state
  logic [7:0]  fade_interval = FADE_INTERVAL_RESET;
  level_vec_t  fade_from     = '0;
  level_vec_t  fade_to       = '0;
  int unsigned step_now      = 0;
  int unsigned step_count    = 0;
  logic [7:0]  tick_acc      = '0;
  logic        fade_active   = 1'b0;

  drive_set_t expected_drives[$];
  drive_set_t want;
  level_vec_t got;
  int         fail_count      = 0;
  int         items_sent      = 0;
  int         gap_max         = 19;
  int         hold_off_cycles = 0;
  int         sink_gap;
  int         cycle_count     = 0;

  rgbw_linear_fade_engine #(
    .LEVEL_BITS(LEVEL_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .channel_0(channel_0),
    .channel_1(channel_1),
    .channel_2(channel_2),
    .channel_3(channel_3),
    .fade_on  (fade_on),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive_0  (drive_0),
    .drive_1  (drive_1),
    .drive_2  (drive_2),
    .drive_3  (drive_3),
    .fade_done(fade_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [LEVEL_BITS-1:0] level_at_step(int ch, int unsigned i);
    int s, d, v;
    s = int'(fade_from[ch]);
    d = int'(fade_to[ch]) - s;
    if (step_count == 0 || i >= step_count) return fade_to[ch];
    v = s + (int'(i) * d) / int'(step_count);
    return v[LEVEL_BITS-1:0];
  endfunction

  function automatic void emit_drive_set();
    drive_set_t r;
    int ch;
    r.done = (step_now >= step_count);
    for (ch = 0; ch < NUM_CH; ch++) r.drive[ch] = level_at_step(ch, step_now);
    expected_drives.push_back(r);
    if (r.done) fade_active = 1'b0;
  endfunction

  function automatic void advance_fader(logic c, level_vec_t lv, logic fade);
    int ch;
    int unsigned dmax, ch_delta, div;
    if (c == CMD_COLOR) begin
      dmax = 0;
      for (ch = 0; ch < NUM_CH; ch++) begin
        ch_delta = (lv[ch] > fade_to[ch]) ? lv[ch] - fade_to[ch] : fade_to[ch] - lv[ch];
        if (ch_delta > dmax) dmax = ch_delta;
        fade_from[ch] = fade_to[ch];
        fade_to[ch]   = lv[ch];
      end
      tick_acc    = '0;
      step_now    = 0;
      step_count  = fade ? dmax : 0;
      fade_active = 1'b1;
      emit_drive_set();
    end else if (fade_active) begin
      div = (fade_interval == 0) ? 1 : fade_interval;
      tick_acc = tick_acc + 8'd1;
      if (tick_acc >= div) begin
        tick_acc = '0;
        if (step_now < step_count) step_now++;
        emit_drive_set();
      end
    end
  endfunction

  function automatic level_vec_t random_levels();
    level_vec_t r;
    int ch;
    for (ch = 0; ch < NUM_CH; ch++) r[ch] = LEVEL_BITS'($urandom_range(0, LEVEL_MAX));
    return r;
  endfunction

  task automatic send_item(logic c, level_vec_t lv, logic fade);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd       = c;
    channel_0 = lv[0];
    channel_1 = lv[1];
    channel_2 = lv[2];
    channel_3 = lv[3];
    fade_on   = fade;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    advance_fader(c, lv, fade);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (expected_drives.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_fade_interval(logic [7:0] val);
    drain_results();
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    fade_interval = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_fade_mix(int n_items, int span);
    level_vec_t goal;
    int ch, v, ticks, pick, first;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        for (ch = 0; ch < NUM_CH; ch++) begin
          v = int'(fade_to[ch]) + int'($urandom_range(0, 2 * span)) - span;
          if (v < 0) v = 0;
          else if (v > LEVEL_MAX) v = LEVEL_MAX;
          goal[ch] = v[LEVEL_BITS-1:0];
        end
        send_item(CMD_COLOR, goal, 1'b1);
        ticks = step_count * ((fade_interval == 0) ? 1 : fade_interval);
        if ($urandom_range(0, 3) == 0) ticks = $urandom_range(0, ticks);
        else ticks += $urandom_range(0, 3);
        repeat (ticks) send_item(CMD_TICK, random_levels(), 1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        send_item(CMD_COLOR, random_levels(), 1'b0);
      end else if (pick < 93) begin
        send_item(CMD_TICK, random_levels(), 1'($urandom_range(0, 1)));
      end else begin
        send_item(CMD_COLOR, random_levels(), 1'b1);
        repeat ($urandom_range(0, 5))
          send_item(CMD_TICK, random_levels(), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_jumps_and_idle_ticks();
    level_vec_t mix;
    mix = {10'h155, 10'h2AA, 10'h155, 10'h2AA};
    send_item(CMD_TICK, random_levels(), 1'b1);
    send_item(CMD_COLOR, {NUM_CH{10'h3FF}}, 1'b0);
    send_item(CMD_COLOR, '0, 1'b0);
    send_item(CMD_COLOR, mix, 1'b0);
    send_item(CMD_COLOR, mix, 1'b1);
    send_item(CMD_TICK, '0, 1'b0);
  endtask

  task automatic test_reset_interval_fades();
    gap_max = 19;
    run_fade_mix(100, 2);
  endtask

  task automatic test_stepped_fades();
    write_fade_interval(8'd2);
    send_item(CMD_COLOR, {10'h156, 10'h2AA, 10'h153, 10'h2AD}, 1'b1);
    repeat (7) send_item(CMD_TICK, random_levels(), 1'b0);
    send_item(CMD_COLOR, {10'h16A, 10'h2BE, 10'h167, 10'h2C1}, 1'b1);
    repeat (2) send_item(CMD_TICK, random_levels(), 1'b1);
    send_item(CMD_COLOR, {10'h156, 10'h2AA, 10'h153, 10'h2AD}, 1'b1);
    repeat (2) send_item(CMD_TICK, random_levels(), 1'b0);
    send_item(CMD_COLOR, {10'h3FF, 10'h000, 10'h3FF, 10'h000}, 1'b0);
    write_fade_interval(8'd0);
    send_item(CMD_COLOR, {10'h3FE, 10'h001, 10'h3FD, 10'h002}, 1'b1);
    repeat (2) send_item(CMD_TICK, random_levels(), 1'b1);
  endtask

  task automatic test_fast_interval();
    write_fade_interval(8'd1);
    gap_max = 19;
    run_fade_mix(250, 20);
    gap_max = 0;
    run_fade_mix(120, 10);
    gap_max = 19;
  endtask

  task automatic test_slow_interval();
    write_fade_interval(8'd255);
    run_fade_mix(280, 1);
  endtask

  task automatic test_mid_intervals();
    repeat (3) begin
      write_fade_interval(8'($urandom_range(2, 9)));
      run_fade_mix(80, 6);
    end
  endtask

  task automatic test_long_fade();
    write_fade_interval(8'd1);
    gap_max = 0;
    send_item(CMD_COLOR, {10'd0, 10'd500, 10'd900, 10'd100}, 1'b0);
    send_item(CMD_COLOR, {10'd330, 10'd820, 10'd600, 10'd420}, 1'b1);
    repeat (331) send_item(CMD_TICK, random_levels(), 1'($urandom_range(0, 1)));
    gap_max = 19;
  endtask

  task automatic test_output_stall();
    drain_results();
    gap_max = 0;
    hold_off_cycles = 400;
    repeat (30) send_item(CMD_COLOR, random_levels(), 1'b0);
    gap_max = 19;
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = CMD_COLOR;
    channel_0 = '0;
    channel_1 = '0;
    channel_2 = '0;
    channel_3 = '0;
    fade_on   = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_jumps_and_idle_ticks();
    test_reset_interval_fades();
    test_stepped_fades();
    test_fast_interval();
    test_slow_interval();
    test_mid_intervals();
    test_long_fade();
    test_output_stall();

    drain_results();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready = 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      sink_gap = $urandom_range(0, gap_max);
      if (sink_gap > 0) begin
        out_ready = 1'b0;
        repeat (sink_gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got = {drive_3, drive_2, drive_1, drive_0};
      if (expected_drives.size() == 0) begin
        $error("unexpected drive set: %h, fade_done %0b", got, fade_done);
        fail_count++;
      end else begin
        want = expected_drives.pop_front();
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (got[ch] !== want.drive[ch]) begin
            $error("drive_%0d: expected %0d, actual %0d", ch, want.drive[ch], got[ch]);
            fail_count++;
          end
        end
        if (fade_done !== want.done) begin
          $error("fade_done: expected %0b, actual %0b", want.done, fade_done);
          fail_count++;
        end
      end
    end
  end

endmodule

@@ sim.f @@
rtl/rlfe_pkg.sv
rtl/rlfe_ctrl.sv
rtl/rlfe_datapath.sv
rtl/rgbw_linear_fade_engine.sv
rtl/rlfe_checker.sv
verif/rgbw_linear_fade_engine_tb.sv
